// File: rtl/core/npos_pkg.sv
// Shared types and constants for the nearest point on segments block.
package npos_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int RAD_WIDTH   = COORD_WIDTH - 1;
  localparam int T_FRAC_BITS = 16;
  localparam int DIST_WIDTH  = 48;
  localparam int DELTA_W     = COORD_WIDTH + 1;
  localparam int MUL_W       = DELTA_W + 1;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int CNT_W       = $clog2(T_FRAC_BITS);
  localparam int SQ_W        = 2 * DELTA_W - 1;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] query_x;
    logic signed [COORD_WIDTH-1:0] query_y;
    logic        [RAD_WIDTH-1:0]   search_radius;
    logic signed [COORD_WIDTH-1:0] seg_start_x;
    logic signed [COORD_WIDTH-1:0] seg_start_y;
    logic signed [COORD_WIDTH-1:0] seg_end_x;
    logic signed [COORD_WIDTH-1:0] seg_end_y;
    logic                          first_segment;
    logic                          last_segment;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] snapped_x;
    logic signed [COORD_WIDTH-1:0] snapped_y;
    logic                          found;
  } out_item_t;

  // Item after the front end: deltas worked out, zero-length segment flagged.
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] qx;
    logic signed [COORD_WIDTH-1:0] qy;
    logic signed [COORD_WIDTH-1:0] ax;
    logic signed [COORD_WIDTH-1:0] ay;
    logic        [RAD_WIDTH-1:0]   rad;
    logic signed [DELTA_W-1:0]     abx;
    logic signed [DELTA_W-1:0]     aby;
    logic signed [DELTA_W-1:0]     apx;
    logic signed [DELTA_W-1:0]     apy;
    logic                          degen;
    logic                          first;
    logic                          last;
  } work_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RAD, ST_L0, ST_L1, ST_D0, ST_D1, ST_CLS, ST_SEL,
    ST_DIV, ST_PX, ST_PY, ST_DX, ST_DY, ST_CMP, ST_EMIT
  } back_state_t;

endpackage

// File: rtl/core/npos_front.sv
// Front end: accepts items, forms the segment deltas and holds a two-entry queue.
module npos_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  npos_pkg::in_item_t in_data,
  output npos_pkg::work_t    q_data,
  output logic               q_valid,
  input  logic               q_pop
);
  import npos_pkg::*;

  work_t      mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  work_t      w;
  logic       do_push, do_pop;

  always_comb begin
    w.qx    = in_data.query_x;
    w.qy    = in_data.query_y;
    w.ax    = in_data.seg_start_x;
    w.ay    = in_data.seg_start_y;
    w.rad   = in_data.search_radius;
    w.abx   = DELTA_W'(in_data.seg_end_x) - DELTA_W'(in_data.seg_start_x);
    w.aby   = DELTA_W'(in_data.seg_end_y) - DELTA_W'(in_data.seg_start_y);
    w.apx   = DELTA_W'(in_data.query_x) - DELTA_W'(in_data.seg_start_x);
    w.apy   = DELTA_W'(in_data.query_y) - DELTA_W'(in_data.seg_start_y);
    w.degen = (in_data.seg_end_x == in_data.seg_start_x) &&
              (in_data.seg_end_y == in_data.seg_start_y);
    w.first = in_data.first_segment;
    w.last  = in_data.last_segment;
  end

  assign in_full = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_data  = mem_r[rd_ptr_r];
  assign do_push = in_push && !in_full;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= w;
    end
  end

endmodule

// File: rtl/core/npos_back.sv
// Back end: projection, division, distance test and result register.
module npos_back (
  input  logic                clk,
  input  logic                rst_n,
  input  npos_pkg::work_t     q_data,
  input  logic                q_valid,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output npos_pkg::out_item_t out_data
);
  import npos_pkg::*;

  localparam logic [DIST_WIDTH-1:0] DMAX = '1;

  back_state_t st_r, st_nxt;

  work_t                        w_r;
  logic signed [PROD_W-1:0]     prod_r;
  logic signed [PROD_W-1:0]     len_r;
  logic signed [PROD_W-1:0]     d_r;
  logic        [PROD_W-1:0]     rem_r;
  logic        [T_FRAC_BITS:0]  t_r;
  logic        [CNT_W-1:0]      cnt_r;
  logic signed [COORD_WIDTH-1:0] px_r, py_r;
  logic        [SQ_W-1:0]       dsq_r;
  logic        [DIST_WIDTH-1:0] min_r;
  logic signed [COORD_WIDTH-1:0] best_x_r, best_y_r;
  logic                         hit_r;
  logic                         out_valid_r;
  out_item_t                    out_r;

  logic signed [MUL_W-1:0]      mul_a, mul_b;
  logic signed [PROD_W-1:0]     mul_p;
  logic signed [PROD_W-1:0]     rnd;
  logic signed [DELTA_W-1:0]    dx, dy;
  logic signed [DELTA_W-1:0]    pnew;
  logic        [PROD_W-1:0]     rem2;
  logic        [SQ_W:0]         dsum;
  logic        [DIST_WIDTH-1:0] dsat;
  logic                         hit_now;
  logic                         slot_free;

  assign dx        = DELTA_W'(w_r.qx) - DELTA_W'(px_r);
  assign dy        = DELTA_W'(w_r.qy) - DELTA_W'(py_r);
  // floor((prod + half) / 2^T) with an arithmetic shift
  assign rnd       = (prod_r + (PROD_W'(1) <<< (T_FRAC_BITS - 1))) >>> T_FRAC_BITS;
  assign rem2      = rem_r << 1;
  assign dsum      = (SQ_W+1)'(dsq_r) + (SQ_W+1)'(prod_r[SQ_W-1:0]);
  assign dsat      = (dsum > (SQ_W+1)'(DMAX)) ? DMAX : dsum[DIST_WIDTH-1:0];
  assign hit_now   = dsat < min_r;
  assign slot_free = !out_valid_r || out_pop;

  always_comb begin
    case (st_r)
      ST_PY:   pnew = DELTA_W'(w_r.ax) + DELTA_W'(rnd);
      default: pnew = DELTA_W'(w_r.ay) + DELTA_W'(rnd);
    endcase
  end

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_r)
      ST_RAD: begin
        mul_a = MUL_W'(w_r.rad);
        mul_b = MUL_W'(w_r.rad);
      end
      ST_L0: begin
        mul_a = MUL_W'(w_r.abx);
        mul_b = MUL_W'(w_r.abx);
      end
      ST_L1: begin
        mul_a = MUL_W'(w_r.aby);
        mul_b = MUL_W'(w_r.aby);
      end
      ST_D0: begin
        mul_a = MUL_W'(w_r.apx);
        mul_b = MUL_W'(w_r.abx);
      end
      ST_D1: begin
        mul_a = MUL_W'(w_r.apy);
        mul_b = MUL_W'(w_r.aby);
      end
      ST_PX: begin
        mul_a = MUL_W'(w_r.abx);
        mul_b = signed'(MUL_W'(t_r));
      end
      ST_PY: begin
        mul_a = MUL_W'(w_r.aby);
        mul_b = signed'(MUL_W'(t_r));
      end
      ST_DX: begin
        mul_a = MUL_W'(dx);
        mul_b = MUL_W'(dx);
      end
      ST_DY: begin
        mul_a = MUL_W'(dy);
        mul_b = MUL_W'(dy);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    st_nxt = st_r;
    q_pop  = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop  = 1'b1;
          st_nxt = ST_RAD;
        end
      end
      ST_RAD: st_nxt = ST_L0;
      ST_L0:  st_nxt = ST_L1;
      ST_L1:  st_nxt = ST_D0;
      ST_D0:  st_nxt = ST_D1;
      ST_D1:  st_nxt = ST_CLS;
      ST_CLS: st_nxt = ST_SEL;
      ST_SEL: begin
        if (w_r.degen || (d_r <= 0) || (d_r >= len_r)) begin
          st_nxt = ST_PX;
        end else begin
          st_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_r == CNT_W'(T_FRAC_BITS - 1)) begin
          st_nxt = ST_PX;
        end
      end
      ST_PX:  st_nxt = ST_PY;
      ST_PY:  st_nxt = ST_DX;
      ST_DX:  st_nxt = ST_DY;
      ST_DY:  st_nxt = ST_CMP;
      ST_CMP: st_nxt = w_r.last ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (slot_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          w_r <= q_data;
        end
      end
      ST_L1:  len_r <= prod_r;
      ST_D0:  len_r <= len_r + prod_r;
      ST_D1:  d_r   <= prod_r;
      ST_CLS: d_r   <= d_r + prod_r;
      ST_SEL: begin
        cnt_r <= '0;
        rem_r <= d_r;
        if (w_r.degen || (d_r <= 0)) begin
          t_r <= '0;
        end else if (d_r >= len_r) begin
          t_r <= (T_FRAC_BITS+1)'(1) << T_FRAC_BITS;
        end else begin
          t_r <= '0;
        end
      end
      ST_DIV: begin
        cnt_r <= cnt_r + 1'b1;
        if (rem2 >= len_r) begin
          rem_r <= rem2 - len_r;
          t_r   <= {t_r[T_FRAC_BITS-1:0], 1'b1};
        end else begin
          rem_r <= rem2;
          t_r   <= {t_r[T_FRAC_BITS-1:0], 1'b0};
        end
      end
      ST_PY:  px_r  <= pnew[COORD_WIDTH-1:0];
      ST_DX:  py_r  <= pnew[COORD_WIDTH-1:0];
      ST_DY:  dsq_r <= prod_r[SQ_W-1:0];
      default: begin
      end
    endcase
  end

  // running best, kept across items of one query
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r    <= '0;
      best_x_r <= '0;
      best_y_r <= '0;
      hit_r    <= 1'b0;
    end else if (st_r == ST_L0 && w_r.first) begin
      // radius squared never exceeds the distance range
      min_r    <= prod_r[DIST_WIDTH-1:0];
      best_x_r <= w_r.qx;
      best_y_r <= w_r.qy;
      hit_r    <= 1'b0;
    end else if (st_r == ST_CMP && hit_now) begin
      min_r    <= dsat;
      best_x_r <= px_r;
      best_y_r <= py_r;
      hit_r    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (st_r == ST_EMIT && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_EMIT && slot_free) begin
      out_r.snapped_x <= hit_r ? best_x_r : w_r.qx;
      out_r.snapped_y <= hit_r ? best_y_r : w_r.qy;
      out_r.found     <= hit_r;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/core/nearest_point_on_segments.sv
// Top level of the nearest point on segments block.
// Each segment of a query is pushed as one item; after the item marked last, one
// result (snapped point and found flag) appears on the output queue. In the back
// end one shared 26x26 multiplier is used in turn for the radius, length, dot
// product, projection and distance terms, and the clamp parameter comes from a
// restoring divider that yields one bit a cycle. Segments of zero length or with
// the parameter clamped skip the divider. The last item of a query passes through
// an emit state to load the result register, and waits there while an earlier
// result is still unpopped. A two-entry queue in front lets up to two further
// items be pushed while one is being worked on, and the result register lets the
// next item start while a result still waits to be popped.
module nearest_point_on_segments (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  npos_pkg::in_item_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output npos_pkg::out_item_t out_data
);
  import npos_pkg::*;

  work_t q_data;
  logic  q_valid;
  logic  q_pop;

  npos_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_data  (q_data),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  npos_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (q_data),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

// File: tb/npos_checker.sv
// Checker for the nearest point on segments block: predicts snapped points and compares.
module npos_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic                in_full,
  input  npos_pkg::in_item_t  in_data,
  input  logic                out_empty,
  input  logic                out_pop,
  input  npos_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending
);
  import npos_pkg::*;

  localparam logic [DIST_WIDTH-1:0] DIST_MAX = '1;

  logic [DIST_WIDTH-1:0] best_dsq;
  logic signed [63:0] best_px, best_py;
  logic hit;
  out_item_t snap_q[$];

  function automatic logic [DIST_WIDTH-1:0] sq_clip(input longint m);
    longint unsigned p;
    if (m > (64'd1 << (DIST_WIDTH / 2))) return DIST_MAX;
    p = m * m;
    return (p > DIST_MAX) ? DIST_MAX : p[DIST_WIDTH-1:0];
  endfunction

  function automatic longint floor_shift(input longint v);
    return v >>> T_FRAC_BITS;
  endfunction

  task automatic snap_segment(input in_item_t it);
    longint qx, qy, ax, ay, abx, aby, apx, apy, px, py, t, dx, dy;
    logic signed [127:0] len, dot, rem;
    longint unsigned q;
    logic [DIST_WIDTH:0] dsq;
    out_item_t r;
    qx = it.query_x; qy = it.query_y;
    ax = it.seg_start_x; ay = it.seg_start_y;
    abx = longint'(it.seg_end_x) - ax; aby = longint'(it.seg_end_y) - ay;
    apx = qx - ax; apy = qy - ay;
    px = ax; py = ay;
    if (it.first_segment) begin
      q = longint'(it.search_radius) * longint'(it.search_radius);
      best_dsq = (q > DIST_MAX) ? DIST_MAX : q[DIST_WIDTH-1:0];
      best_px = qx; best_py = qy; hit = 1'b0;
    end
    len = 128'(abx) * abx + 128'(aby) * aby;
    if (len != 0) begin
      dot = 128'(apx) * abx + 128'(apy) * aby;
      if (dot <= 0) t = 0;
      else if (dot >= len) t = 64'd1 << T_FRAC_BITS;
      else begin
        rem = (dot <<< T_FRAC_BITS) / len;
        t = rem[63:0];
      end
      px = ax + floor_shift(abx * t + (64'd1 << (T_FRAC_BITS - 1)));
      py = ay + floor_shift(aby * t + (64'd1 << (T_FRAC_BITS - 1)));
    end
    dx = qx - px; dy = qy - py;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    dsq = sq_clip(dx) + sq_clip(dy);
    if (dsq > DIST_MAX) dsq = DIST_MAX;
    if (dsq[DIST_WIDTH-1:0] < best_dsq) begin
      best_dsq = dsq[DIST_WIDTH-1:0]; best_px = px; best_py = py; hit = 1'b1;
    end
    if (it.last_segment) begin
      r.snapped_x = hit ? best_px[COORD_WIDTH-1:0] : it.query_x;
      r.snapped_y = hit ? best_py[COORD_WIDTH-1:0] : it.query_y;
      r.found = hit;
      snap_q.push_back(r);
    end
  endtask

  assign pending = snap_q.size();

  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst_n) begin
      best_dsq = '0; best_px = 0; best_py = 0; hit = 1'b0;
      fail_count <= 0;
      snap_q.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (snap_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = snap_q.pop_front();
          if (exp_r.snapped_x !== out_data.snapped_x || exp_r.snapped_y !== out_data.snapped_y
              || exp_r.found !== out_data.found) begin
            $display("%0t: mismatch x/y/found expected %h/%h/%b got %h/%h/%b", $time,
                     exp_r.snapped_x, exp_r.snapped_y, exp_r.found,
                     out_data.snapped_x, out_data.snapped_y, out_data.found);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_push && !in_full) snap_segment(in_data);
    end
  end

endmodule

// File: tb/tb_nearest_point_on_segments.sv
// Testbench top for the nearest point on segments block: stimulus and verdict.
module tb_nearest_point_on_segments;
  import npos_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  in_item_t in_data = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  out_item_t out_data;
  int fail_count, pending;
  bit hold_results = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  nearest_point_on_segments dut (
    .clk, .rst_n, .in_push, .in_full, .in_data, .out_empty, .out_pop, .out_data
  );

  npos_checker chk (
    .clk, .rst_n, .in_push, .in_full, .in_data, .out_empty, .out_pop, .out_data,
    .fail_count, .pending
  );

  function automatic int gap_len();
    int r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] coord(input logic signed [23:0] c);
    case ($urandom_range(0, 5))
      0: return 24'($urandom);
      1: return 24'sh7FFFFF - 24'($urandom_range(0, 3));
      2: return 24'sh800000 + 24'($urandom_range(0, 3));
      default: return c + $signed(24'($urandom_range(0, 8191)) - 24'sd4096);
    endcase
  endfunction

  // one transfer into the block; inputs change on the falling edge
  task automatic send(input in_item_t it);
    int g = gap_len();
    @(negedge clk);
    if (g > 0) begin
      in_push <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_data <= it;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
  endtask

  task automatic stop_push();
    @(negedge clk);
    in_push <= 1'b0;
  endtask

  task automatic send_seg(input logic signed [23:0] qx, qy, ax, ay, bx, by,
                          input logic [22:0] rad, input bit f, l);
    in_item_t it;
    it.query_x = qx; it.query_y = qy; it.search_radius = rad;
    it.seg_start_x = ax; it.seg_start_y = ay; it.seg_end_x = bx; it.seg_end_y = by;
    it.first_segment = f; it.last_segment = l;
    send(it);
  endtask

  // result side: random stalls, with a long hold-off on request
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_results) begin
        out_pop <= 1'b0;
        repeat (400) @(negedge clk);
        hold_results = 1'b0;
      end else
        out_pop <= (gap_len() == 0) || ($urandom_range(0, 2) == 0);
    end
  end

  initial begin
    in_item_t it;
    logic signed [23:0] cx, cy;
    int n;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // without a first item nothing can be kept
    send_seg(24'sd100, 24'sd100, 24'sd0, 24'sd0, 24'sd200, 24'sd0, 23'h7FFFFF, 0, 1);
    send_seg(24'sd0, 24'sd0, 24'sd5, 24'sd5, 24'sd5, 24'sd5, 23'd100, 1, 1);
    send_seg(24'sd0, 24'sd0, 24'sd5, 24'sd5, 24'sd5, 24'sd5, 23'd7, 1, 1);
    send_seg(24'sd10, 24'sd10, 24'sd0, 24'sd0, 24'sd20, 24'sd0, 23'd20, 1, 0);
    send_seg(24'sd10, 24'sd10, 24'sd0, 24'sd20, 24'sd20, 24'sd20, 23'd0, 0, 0);
    send_seg(24'sd10, 24'sd10, 24'sd0, 24'sd0, 24'sd0, 24'sd20, 23'd0, 0, 1);
    send_seg(24'sd0, 24'sd0, 24'sd100, 24'sd100, 24'sd300, 24'sd100, 23'd500, 1, 1);
    send_seg(24'sd500, 24'sd0, 24'sd100, 24'sd100, 24'sd300, 24'sd100, 23'd500, 1, 1);
    send_seg(24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF,
             24'sh800000, 23'h7FFFFF, 1, 1);
    send_seg(24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000,
             24'sh800000, 23'h7FFFFF, 1, 0);
    send_seg(24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
             24'sh7FFFFF, 23'h7FFFFF, 0, 1);
    send_seg(24'sd3, 24'sd7, 24'sd0, 24'sd0, 24'sd3, 24'sd1, 23'd40, 1, 0);
    send_seg(24'sd3, 24'sd7, 24'sd0, 24'sd0, 24'sd3, 24'sd1, 23'd40, 0, 1);
    send_seg(24'sd3, 24'sd7, 24'sd1, 24'sd0, 24'sd6, 24'sd1, 23'd40, 0, 1);
    // pause until the block has drained
    stop_push();
    wait (pending == 0);
    // random queries, mostly well formed; now and then a missing first or noise
    for (int q = 0; q < 500; q++) begin
      if (q == 150) hold_results = 1'b1;
      if (q == 300) begin
        stop_push();
        wait (pending == 0);
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
      cx = 24'($urandom); cy = 24'($urandom);
      if ($urandom_range(0, 2) != 0) begin
        cx = cx >>> $urandom_range(4, 14); cy = cy >>> $urandom_range(4, 14);
      end
      for (int s = 0; s < n; s++) begin
        it.query_x = coord(cx); it.query_y = coord(cy);
        if ($urandom_range(0, 3) != 0) begin it.query_x = cx; it.query_y = cy; end
        it.search_radius = ($urandom_range(0, 3) == 0) ? 23'($urandom)
                           : 23'($urandom_range(0, 12000));
        it.seg_start_x = coord(cx); it.seg_start_y = coord(cy);
        if ($urandom_range(0, 9) == 0) begin
          it.seg_end_x = it.seg_start_x; it.seg_end_y = it.seg_start_y;
        end else begin
          it.seg_end_x = coord(cx); it.seg_end_y = coord(cy);
        end
        it.first_segment = (s == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 29) == 0);
        it.last_segment = (s == n - 1) ? 1'b1 : ($urandom_range(0, 29) == 0);
        send(it);
      end
    end
    stop_push();
    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: nearest_point_on_segments.f
rtl/core/npos_pkg.sv
rtl/core/npos_front.sv
rtl/core/npos_back.sv
rtl/core/nearest_point_on_segments.sv
tb/npos_checker.sv
tb/tb_nearest_point_on_segments.sv
